>>> design/mfrs_pkg.sv
// shared types, constants and the row remap table for the frame store scan-out block
// no dependencies; every other design file refers to it by scoped names
package mfrs_pkg;

    localparam int PIXEL_COLUMNS  = 144;
    localparam int PIXEL_ROWS     = 65;
    localparam int PAGE_COUNT     = 9;
    localparam int GROUPS_PER_ROW = 18;
    localparam int REMAP_LEN      = 65;

    localparam int STORE_BYTES = PAGE_COUNT * PIXEL_COLUMNS;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int SCAN_CYCLES = GROUPS_PER_ROW * 8;
    localparam int CNT_W       = ADDR_W;
    localparam int WIDE_W      = 13;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_SCAN  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] x_pos;
        logic [7:0] y_pos;
        logic       pixel_on;
        logic [6:0] row_select;
    } request_t;

    typedef struct packed {
        logic [7:0] row_byte;
        logic [4:0] column_group;
        logic       last_byte;
    } result_t;

    typedef enum logic [2:0] {
        ADDR_HOLD,
        ADDR_ZERO,
        ADDR_WR,
        ADDR_SCAN,
        ADDR_INC
    } addr_op_t;

    typedef struct packed {
        logic       load;
        addr_op_t   addr_op;
        logic       mem_rd;
        logic       mem_wr;
        logic       wr_zero;
        logic       gather;
        logic       emit;
        logic [4:0] group;
        logic       last;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       wr_ok;
        logic       page_ok;
    } dp_status_t;

    // physical row to logical row, interlaced com order
    function automatic logic [6:0] remap_row(input logic [6:0] row);
        logic [6:0] r;
        r = row;
        unique case (row)
            7'd0:  r = 7'd32;
            7'd1:  r = 7'd15;
            7'd2:  r = 7'd31;
            7'd3:  r = 7'd14;
            7'd4:  r = 7'd30;
            7'd5:  r = 7'd13;
            7'd6:  r = 7'd29;
            7'd7:  r = 7'd12;
            7'd8:  r = 7'd28;
            7'd9:  r = 7'd11;
            7'd10: r = 7'd27;
            7'd11: r = 7'd10;
            7'd12: r = 7'd26;
            7'd13: r = 7'd9;
            7'd14: r = 7'd25;
            7'd15: r = 7'd8;
            7'd16: r = 7'd24;
            7'd17: r = 7'd7;
            7'd18: r = 7'd23;
            7'd19: r = 7'd6;
            7'd20: r = 7'd22;
            7'd21: r = 7'd5;
            7'd22: r = 7'd21;
            7'd23: r = 7'd4;
            7'd24: r = 7'd20;
            7'd25: r = 7'd3;
            7'd26: r = 7'd19;
            7'd27: r = 7'd2;
            7'd28: r = 7'd18;
            7'd29: r = 7'd1;
            7'd30: r = 7'd17;
            7'd31: r = 7'd0;
            7'd64: r = 7'd65;
            // rows 32 to 63 shift up by one, rows past the table map to themselves
            default: r = (row < 7'd64) ? row + 7'd1 : row;
        endcase
        return r;
    endfunction

endpackage

>>> design/mfrs_ctrl.sv
// controller state machine: request dispatch, pixel read-modify-write, row scan, clear sweep
// depends on mfrs_pkg for command and status types
module mfrs_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  mfrs_pkg::dp_status_t  status,
    output logic                  busy,
    output mfrs_pkg::ctrl_cmd_t   cmd
);

    localparam int CNT_W = mfrs_pkg::CNT_W;

    typedef enum logic [2:0] {
        S_CLR_START,
        S_IDLE,
        S_DISPATCH,
        S_WR_READ,
        S_WR_WRITE,
        S_SCAN,
        S_CLEAR
    } state_t;

    state_t                       state_reg, state_next;
    logic                         busy_reg;
    logic [mfrs_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [4:0]                   group;

    assign group = cnt_reg[3 +: 5];
    assign busy  = busy_reg;

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        cmd.addr_op  = mfrs_pkg::ADDR_HOLD;
        cmd.group    = group;
        cmd.last     = (group == 5'(mfrs_pkg::GROUPS_PER_ROW - 1));
        unique case (state_reg)
            S_CLR_START:
            begin
                cmd.addr_op = mfrs_pkg::ADDR_ZERO;
                cnt_next    = '0;
                state_next  = S_CLEAR;
            end
            S_IDLE:
            begin
                cmd.load = start;
                if (start)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                cnt_next = '0;
                unique case (status.op)
                    mfrs_pkg::OP_WRITE:
                    begin
                        if (status.wr_ok)
                        begin
                            cmd.addr_op = mfrs_pkg::ADDR_WR;
                            state_next  = S_WR_READ;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    mfrs_pkg::OP_SCAN:
                    begin
                        cmd.addr_op = mfrs_pkg::ADDR_SCAN;
                        state_next  = S_SCAN;
                    end
                    mfrs_pkg::OP_CLEAR:
                    begin
                        cmd.addr_op = mfrs_pkg::ADDR_ZERO;
                        state_next  = S_CLEAR;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_WR_READ:
            begin
                cmd.mem_rd = 1'b1;
                state_next = S_WR_WRITE;
            end
            S_WR_WRITE:
            begin
                cmd.mem_wr = 1'b1;
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                // columns past the image or pages past the store read as zero
                cmd.mem_rd  = status.page_ok
                              && (cnt_reg < CNT_W'(mfrs_pkg::PIXEL_COLUMNS));
                cmd.gather  = 1'b1;
                cmd.emit    = (cnt_reg[2:0] == 3'd7);
                cmd.addr_op = mfrs_pkg::ADDR_INC;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(mfrs_pkg::SCAN_CYCLES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_CLEAR:
            begin
                cmd.mem_wr  = 1'b1;
                cmd.wr_zero = 1'b1;
                cmd.addr_op = mfrs_pkg::ADDR_INC;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(mfrs_pkg::STORE_BYTES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR_START;
            busy_reg  <= 1'b1;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
            cnt_reg   <= cnt_next;
        end
    end

endmodule

>>> design/mfrs_dpath.sv
// datapath: request register, frame store memory, address counter, bit gather and result register
// depends on mfrs_pkg for request, result, command and status types
module mfrs_dpath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mfrs_pkg::ctrl_cmd_t   cmd,
    input  mfrs_pkg::request_t    request,
    output mfrs_pkg::dp_status_t  status,
    output mfrs_pkg::result_t     result,
    output logic                  result_valid
);

    localparam int ADDR_W = mfrs_pkg::ADDR_W;
    localparam int WIDE_W = mfrs_pkg::WIDE_W;

    logic [7:0]              mem [mfrs_pkg::STORE_BYTES];

    mfrs_pkg::request_t      req_reg;
    logic [6:0]              logical_reg;
    logic [ADDR_W-1:0]       addr_reg;
    logic [7:0]              rdata_reg;
    logic [7:0]              acc_reg;
    mfrs_pkg::result_t       result_reg;
    logic                    result_valid_reg;
    logic                    take_pipe_reg;
    logic                    gather_pipe_reg;
    logic                    emit_pipe_reg;
    logic [4:0]              group_pipe_reg;
    logic                    last_pipe_reg;

    logic [4:0]              wr_page;
    logic [3:0]              scan_page;
    logic [WIDE_W-1:0]       wr_addr_full;
    logic [WIDE_W-1:0]       scan_addr_full;
    logic [7:0]              wr_mask;
    logic [7:0]              wr_data;
    logic                    pix_bit;
    logic [7:0]              acc_next;

    assign wr_page   = req_reg.y_pos[7:3];
    assign scan_page = logical_reg[6:3];

    assign wr_addr_full   = WIDE_W'(wr_page) * WIDE_W'(mfrs_pkg::PIXEL_COLUMNS)
                            + WIDE_W'(req_reg.x_pos);
    assign scan_addr_full = WIDE_W'(scan_page) * WIDE_W'(mfrs_pkg::PIXEL_COLUMNS);

    assign status.op      = req_reg.operation;
    assign status.wr_ok   = ({1'b0, req_reg.x_pos} < 9'(mfrs_pkg::PIXEL_COLUMNS))
                            && ({1'b0, req_reg.y_pos} < 9'(mfrs_pkg::PIXEL_ROWS))
                            && ({1'b0, wr_page} < 6'(mfrs_pkg::PAGE_COUNT));
    assign status.page_ok = ({1'b0, scan_page} < 5'(mfrs_pkg::PAGE_COUNT));

    assign wr_mask = 8'h01 << req_reg.y_pos[2:0];
    assign wr_data = cmd.wr_zero        ? 8'h00 :
                     req_reg.pixel_on   ? (rdata_reg | wr_mask) :
                                          (rdata_reg & ~wr_mask);

    // skipped reads shift in a blank pixel
    assign pix_bit  = take_pipe_reg & rdata_reg[logical_reg[2:0]];
    assign acc_next = {acc_reg[6:0], pix_bit};

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr)
        begin
            mem[addr_reg] <= wr_data;
        end
        if (cmd.mem_rd)
        begin
            rdata_reg <= mem[addr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg     <= request;
            logical_reg <= mfrs_pkg::remap_row(request.row_select);
        end
        unique case (cmd.addr_op)
            mfrs_pkg::ADDR_ZERO: addr_reg <= '0;
            mfrs_pkg::ADDR_WR:   addr_reg <= wr_addr_full[ADDR_W-1:0];
            mfrs_pkg::ADDR_SCAN: addr_reg <= scan_addr_full[ADDR_W-1:0];
            mfrs_pkg::ADDR_INC:  addr_reg <= addr_reg + 1'b1;
            default:             addr_reg <= addr_reg;
        endcase
        group_pipe_reg <= cmd.group;
        last_pipe_reg  <= cmd.last;
        if (gather_pipe_reg)
        begin
            acc_reg <= acc_next;
        end
        if (emit_pipe_reg)
        begin
            result_reg.row_byte     <= acc_next;
            result_reg.column_group <= group_pipe_reg;
            result_reg.last_byte    <= last_pipe_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            take_pipe_reg    <= 1'b0;
            gather_pipe_reg  <= 1'b0;
            emit_pipe_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            take_pipe_reg    <= cmd.mem_rd & cmd.gather;
            gather_pipe_reg  <= cmd.gather;
            emit_pipe_reg    <= cmd.emit;
            result_valid_reg <= emit_pipe_reg;
        end
    end

endmodule

>>> design/mono_framebuffer_row_scanout.sv
// row scan: accept, dispatch, then store reads at one read per cycle on the single frame
// store port; one result byte is strobed per column group.
// pixel write: read-modify-write of one store byte; clear: one byte per cycle.
// results are strobed for one cycle and cannot be stalled.
// after reset the block sweeps the store to zero with busy high.
module mono_framebuffer_row_scanout (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  mfrs_pkg::request_t  request,
    output mfrs_pkg::result_t   result,
    output logic                result_valid
);

    mfrs_pkg::ctrl_cmd_t   cmd;
    mfrs_pkg::dp_status_t  status;

    mfrs_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .busy   (busy),
        .cmd    (cmd)
    );

    mfrs_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .request      (request),
        .status       (status),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule

>>> design/mfrs_checker.sv
// port-level checker for the frame store scan-out block, with its bind to the top level
// depends on mfrs_pkg for the request and result types
module mfrs_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input mfrs_pkg::request_t  request,
    input mfrs_pkg::result_t   result,
    input logic                result_valid
);

    // an accepted request always raises busy in the cycle after it
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted request");

    // result strobes are never back to back
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("back to back result strobes");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.last_byte)
        |-> (result.column_group == 5'(mfrs_pkg::GROUPS_PER_ROW - 1)))
        else $error("last byte on wrong column group");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.last_byte)
        |-> ##8 (result_valid
                 && (result.column_group == $past(result.column_group, 8) + 5'd1)))
        else $error("column group sequence broken");

endmodule

bind mono_framebuffer_row_scanout mfrs_checker u_mfrs_checker (.*);
